[src/mdau_pkg.sv]
// Package for the multiply / divide / accumulate unit.
// Holds register codes, mode codes, state types and the core request struct.
// No dependencies.
`timescale 1ns / 1ps

package mdau_pkg;

    localparam int OPND_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 40;
    localparam int BYTE_W = 8;
    localparam int SEL_W  = 3;
    localparam int CNT_W  = 4;

    // Access kind
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Write selects
    localparam logic [SEL_W-1:0] WR_CTRL = 3'd0;
    localparam logic [SEL_W-1:0] WR_A_LO = 3'd1;
    localparam logic [SEL_W-1:0] WR_A_HI = 3'd2;
    localparam logic [SEL_W-1:0] WR_B_LO = 3'd3;
    localparam logic [SEL_W-1:0] WR_B_HI = 3'd4;

    // Read selects
    localparam logic [SEL_W-1:0] RD_SUM0   = 3'd0;
    localparam logic [SEL_W-1:0] RD_SUM1   = 3'd1;
    localparam logic [SEL_W-1:0] RD_SUM2   = 3'd2;
    localparam logic [SEL_W-1:0] RD_SUM3   = 3'd3;
    localparam logic [SEL_W-1:0] RD_SUM4   = 3'd4;
    localparam logic [SEL_W-1:0] RD_STATUS = 3'd5;

    localparam logic [BYTE_W-1:0] STATUS_OVERFLOW = 8'h80;

    // Arithmetic modes; modes two and three both accumulate
    localparam logic [1:0] MODE_MUL = 2'd0;
    localparam logic [1:0] MODE_DIV = 2'd1;

    // Control byte bit that clears the sum
    localparam int CTRL_CLEAR_BIT = 1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } top_state_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_STEP,
        CORE_FIX,
        CORE_DONE
    } core_state_t;

    typedef struct packed {
        logic start;
        logic divide;
    } core_req_t;

endpackage

[src/multiply_divide_accumulate_unit.sv]
// Byte-wide register-mapped multiply / divide / accumulate unit.
// Operand registers, 40-bit sum, status and handshake; depends on mdau_pkg, mdau_serial_core.
// A result is offered the cycle after each transfer. The operand B high write runs the
// operation unless it is a divide by zero, which clears the sum instead: the input is
// held off for sixteen bit-serial core steps, a sign fixup and the sum update.
// Reset (synchronous, active low) clears operands, sum, overflow, mode, state and result valid.
`timescale 1ns / 1ps

module multiply_divide_accumulate_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [mdau_pkg::SEL_W-1:0]       s_reg_select,
    input  logic [mdau_pkg::BYTE_W-1:0]      s_write_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mdau_pkg::BYTE_W-1:0]      m_read_data
);

    mdau_pkg::top_state_t state_reg, state_next;

    logic [mdau_pkg::OPND_W-1:0] opa_reg, opa_next;
    logic [mdau_pkg::OPND_W-1:0] opb_reg, opb_next;
    logic [mdau_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic                        ovf_reg, ovf_next;
    logic [1:0]                  mode_reg, mode_next;
    logic                        mvalid_reg, mvalid_next;
    logic [mdau_pkg::BYTE_W-1:0] mdata_reg, mdata_next;

    logic                        take;
    logic                        wr;
    logic [mdau_pkg::OPND_W-1:0] opb_new;
    logic                        run_hit;
    logic                        div_zero;
    mdau_pkg::core_req_t         core_req;
    logic                        core_done;
    logic [mdau_pkg::PROD_W-1:0] core_result;
    logic [mdau_pkg::SUM_W:0]    acc_sum;
    logic [mdau_pkg::BYTE_W-1:0] rd_byte;

    assign take     = s_valid & s_ready;
    assign wr       = (s_opcode == mdau_pkg::OP_WRITE);
    assign opb_new  = {s_write_data, opb_reg[mdau_pkg::BYTE_W-1:0]};
    assign run_hit  = take & wr & (s_reg_select == mdau_pkg::WR_B_HI);
    assign div_zero = (mode_reg == mdau_pkg::MODE_DIV) && (opb_new == '0);

    assign acc_sum = {1'b0, sum_reg}
                   + {1'b0, {(mdau_pkg::SUM_W-mdau_pkg::PROD_W){core_result[mdau_pkg::PROD_W-1]}},
                      core_result};

    mdau_serial_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (core_req),
        .op_a    (opa_reg),
        .op_b    (opb_new),
        .done    (core_done),
        .result  (core_result)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mdau_pkg::ST_IDLE: begin
                if (core_req.start) state_next = mdau_pkg::ST_BUSY;
            end
            mdau_pkg::ST_BUSY: begin
                if (core_done) state_next = mdau_pkg::ST_IDLE;
            end
            default: state_next = mdau_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        s_ready         = 1'b0;
        core_req.start  = 1'b0;
        core_req.divide = (mode_reg == mdau_pkg::MODE_DIV);
        case (state_reg)
            mdau_pkg::ST_IDLE: begin
                s_ready        = !mvalid_reg || m_ready;
                core_req.start = run_hit && !div_zero;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (s_reg_select)
            mdau_pkg::RD_SUM0:   rd_byte = sum_reg[7:0];
            mdau_pkg::RD_SUM1:   rd_byte = sum_reg[15:8];
            mdau_pkg::RD_SUM2:   rd_byte = sum_reg[23:16];
            mdau_pkg::RD_SUM3:   rd_byte = sum_reg[31:24];
            mdau_pkg::RD_SUM4:   rd_byte = sum_reg[39:32];
            mdau_pkg::RD_STATUS: rd_byte = ovf_reg ? mdau_pkg::STATUS_OVERFLOW : 8'h00;
            default:             rd_byte = 8'h00;
        endcase
    end

    always_comb begin
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        sum_next    = sum_reg;
        ovf_next    = ovf_reg;
        mode_next   = mode_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        // drop the result once taken, load a fresh one on each transfer
        if (m_ready) mvalid_next = 1'b0;
        if (take) begin
            mvalid_next = 1'b1;
            mdata_next  = wr ? 8'h00 : rd_byte;
        end

        if (take && wr) begin
            case (s_reg_select)
                mdau_pkg::WR_CTRL: begin
                    if (s_write_data[mdau_pkg::CTRL_CLEAR_BIT]) sum_next = '0;
                    mode_next = s_write_data[1:0];
                end
                mdau_pkg::WR_A_LO: opa_next[7:0]  = s_write_data;
                mdau_pkg::WR_A_HI: opa_next[15:8] = s_write_data;
                mdau_pkg::WR_B_LO: opb_next[7:0]  = s_write_data;
                mdau_pkg::WR_B_HI: begin
                    // core latches the operands at this edge, so clear B now, and A as well when dividing
                    opb_next = '0;
                    if (mode_reg == mdau_pkg::MODE_DIV) begin
                        opa_next = '0;
                        if (div_zero) sum_next = '0;
                    end
                end
                default: ;
            endcase
        end

        if (core_done) begin
            if (mode_reg == mdau_pkg::MODE_MUL || mode_reg == mdau_pkg::MODE_DIV) begin
                sum_next = {{(mdau_pkg::SUM_W-mdau_pkg::PROD_W){1'b0}}, core_result};
            end else begin
                sum_next = acc_sum[mdau_pkg::SUM_W-1:0];
                ovf_next = acc_sum[mdau_pkg::SUM_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mdau_pkg::ST_IDLE;
            opa_reg    <= '0;
            opb_reg    <= '0;
            sum_reg    <= '0;
            ovf_reg    <= 1'b0;
            mode_reg   <= mdau_pkg::MODE_MUL;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            opa_reg    <= opa_next;
            opb_reg    <= opb_next;
            sum_reg    <= sum_next;
            ovf_reg    <= ovf_next;
            mode_reg   <= mode_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mdata_reg <= mdata_next;
    end

    assign m_valid     = mvalid_reg;
    assign m_read_data = mdata_reg;

endmodule

[src/mdau_serial_core.sv]
// Bit-serial arithmetic core: shift-add multiply and restoring divide.
// One bit per cycle over sixteen steps, then a sign fixup step.
// Depends on mdau_pkg.
`timescale 1ns / 1ps

module mdau_serial_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mdau_pkg::core_req_t             req,
    input  logic [mdau_pkg::OPND_W-1:0]     op_a,
    input  logic [mdau_pkg::OPND_W-1:0]     op_b,
    output logic                            done,
    output logic [mdau_pkg::PROD_W-1:0]     result
);

    mdau_pkg::core_state_t state_reg, state_next;

    logic [mdau_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [mdau_pkg::OPND_W-1:0] hi_reg, hi_next;     // partial product / partial remainder
    logic [mdau_pkg::OPND_W-1:0] lo_reg, lo_next;     // multiplier / dividend-quotient shifter
    logic [mdau_pkg::OPND_W-1:0] oper_reg, oper_next; // multiplicand magnitude or divisor
    logic                        neg_reg, neg_next;
    logic                        div_reg, div_next;
    logic [mdau_pkg::PROD_W-1:0] res_reg, res_next;

    logic                        step_en;
    logic                        fix_en;
    logic [mdau_pkg::OPND_W-1:0] mag_a;
    logic [mdau_pkg::OPND_W-1:0] mag_b;
    logic [mdau_pkg::OPND_W:0]   mul_sum;
    logic [mdau_pkg::OPND_W+1:0] div_trial;
    logic [mdau_pkg::PROD_W-1:0] mag_prod;
    logic [mdau_pkg::OPND_W-1:0] quo_fix;
    logic [mdau_pkg::OPND_W-1:0] rem_fix;

    assign mag_a = op_a[mdau_pkg::OPND_W-1] ? (~op_a + 16'd1) : op_a;
    assign mag_b = op_b[mdau_pkg::OPND_W-1] ? (~op_b + 16'd1) : op_b;

    assign mul_sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, oper_reg} : 17'd0);
    assign div_trial = {1'b0, hi_reg, lo_reg[mdau_pkg::OPND_W-1]} - {2'b00, oper_reg};
    assign mag_prod  = {hi_reg, lo_reg};

    // Floor division for a negative dividend: bump the quotient and fold the remainder
    always_comb begin
        if (!neg_reg) begin
            quo_fix = lo_reg;
            rem_fix = hi_reg;
        end else if (hi_reg != '0) begin
            quo_fix = ~lo_reg;
            rem_fix = oper_reg - hi_reg;
        end else begin
            quo_fix = ~lo_reg + 16'd1;
            rem_fix = '0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mdau_pkg::CORE_IDLE: begin
                if (req.start) state_next = mdau_pkg::CORE_STEP;
            end
            mdau_pkg::CORE_STEP: begin
                if (cnt_reg == '1) state_next = mdau_pkg::CORE_FIX;
            end
            mdau_pkg::CORE_FIX:  state_next = mdau_pkg::CORE_DONE;
            mdau_pkg::CORE_DONE: state_next = mdau_pkg::CORE_IDLE;
            default:             state_next = mdau_pkg::CORE_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        step_en = 1'b0;
        fix_en  = 1'b0;
        done    = 1'b0;
        case (state_reg)
            mdau_pkg::CORE_STEP: step_en = 1'b1;
            mdau_pkg::CORE_FIX:  fix_en  = 1'b1;
            mdau_pkg::CORE_DONE: done    = 1'b1;
            default: ;
        endcase
    end

    // Datapath
    always_comb begin
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        oper_next = oper_reg;
        neg_next  = neg_reg;
        div_next  = div_reg;
        res_next  = res_reg;
        if (state_reg == mdau_pkg::CORE_IDLE && req.start) begin
            cnt_next = '0;
            hi_next  = '0;
            div_next = req.divide;
            if (req.divide) begin
                lo_next   = mag_a;
                oper_next = op_b;
                neg_next  = op_a[mdau_pkg::OPND_W-1];
            end else begin
                lo_next   = mag_b;
                oper_next = mag_a;
                neg_next  = op_a[mdau_pkg::OPND_W-1] ^ op_b[mdau_pkg::OPND_W-1];
            end
        end else if (step_en) begin
            cnt_next = cnt_reg + 4'd1;
            if (div_reg) begin
                // keep the trial difference when it did not go negative
                if (!div_trial[mdau_pkg::OPND_W+1]) begin
                    hi_next = div_trial[mdau_pkg::OPND_W-1:0];
                end else begin
                    hi_next = {hi_reg[mdau_pkg::OPND_W-2:0], lo_reg[mdau_pkg::OPND_W-1]};
                end
                lo_next = {lo_reg[mdau_pkg::OPND_W-2:0], ~div_trial[mdau_pkg::OPND_W+1]};
            end else begin
                hi_next = mul_sum[mdau_pkg::OPND_W:1];
                lo_next = {mul_sum[0], lo_reg[mdau_pkg::OPND_W-1:1]};
            end
        end else if (fix_en) begin
            if (div_reg) begin
                res_next = {rem_fix, quo_fix};
            end else begin
                res_next = neg_reg ? (~mag_prod + 32'd1) : mag_prod;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mdau_pkg::CORE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        hi_reg   <= hi_next;
        lo_reg   <= lo_next;
        oper_reg <= oper_next;
        neg_reg  <= neg_next;
        div_reg  <= div_next;
        res_reg  <= res_next;
    end

    assign result = res_reg;

endmodule
